>>> rtl/sbb_pkg.sv
// shared types and constants for the stereo cabinet band-pass blend
// widths, register indexes, sequencer codes and controller/datapath command structs
// no dependencies
package sbb_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 16;
  localparam int STATE_BITS  = 32;
  localparam int UP          = STATE_BITS - SAMPLE_BITS;
  localparam int MIX_W       = COEFF_BITS + 1;
  localparam int DIFF_W      = STATE_BITS + 2;
  localparam int PROD_W      = DIFF_W + MIX_W + 1;
  localparam int SH_W        = PROD_W - COEFF_BITS;
  localparam int BLEND_W     = SH_W + 1;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_CORNER  = 2'd0,
    CFG_HIGH_CORNER = 2'd1,
    CFG_WET_MIX     = 2'd2
  } cfg_idx_t;

  localparam logic [COEFF_BITS-1:0] LOW_CORNER_RESET  = COEFF_BITS'(683);
  localparam logic [COEFF_BITS-1:0] HIGH_CORNER_RESET = COEFF_BITS'(14496);
  localparam logic [MIX_W-1:0]      MIX_ONE           = MIX_W'(1) << COEFF_BITS;

  typedef enum logic [1:0] {
    STEP_LP1,
    STEP_LP2,
    STEP_TRK,
    STEP_MIX
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_PASS
  } state_t;

  typedef struct packed {
    step_t step;
    logic  load;
    logic  mul_en;
    logic  add_en;
    logic  out_load;
    logic  bypass;
  } cmd_t;

  typedef struct packed {
    logic mix_zero;
  } status_t;

endpackage

>>> rtl/sbb_lane.sv
// one channel of the band-pass datapath: pole state, shared multiplier, blend and saturation
// depends on sbb_pkg
module sbb_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  sbb_pkg::cmd_t                       cmd,
  input  logic signed [sbb_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic [sbb_pkg::MIX_W-1:0]           coef,
  output logic signed [sbb_pkg::SAMPLE_BITS-1:0] sample_out
);
  import sbb_pkg::*;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [STATE_BITS-1:0]  lp1, lp2, trk;
  logic signed [PROD_W-1:0]      prod;
  logic signed [STATE_BITS-1:0]  dry;
  logic signed [DIFF_W-1:0]      op_a, op_b, diff;
  logic signed [STATE_BITS-1:0]  base;
  logic signed [PROD_W-1:0]      prod_next, prod_sh;
  logic signed [SH_W-1:0]        sh;
  logic signed [SH_W-1:0]        pole_sum;
  logic signed [STATE_BITS-1:0]  pole_new;
  logic signed [BLEND_W-1:0]     blend, blend_sh;
  logic signed [SAMPLE_BITS-1:0] blend_sat;
  logic                          fits;

  assign dry = {sample, {UP{1'b0}}};

  always_comb begin
    op_a = DIFF_W'(dry);
    op_b = DIFF_W'(lp1);
    base = lp1;
    case (cmd.step)
      STEP_LP1: begin
        op_a = DIFF_W'(dry);
        op_b = DIFF_W'(lp1);
        base = lp1;
      end
      STEP_LP2: begin
        op_a = DIFF_W'(lp1);
        op_b = DIFF_W'(lp2);
        base = lp2;
      end
      STEP_TRK: begin
        op_a = DIFF_W'(lp2);
        op_b = DIFF_W'(trk);
        base = trk;
      end
      STEP_MIX: begin
        // wet = second lowpass minus tracker, then wet - dry
        op_a = DIFF_W'(lp2) - DIFF_W'(trk);
        op_b = DIFF_W'(dry);
        base = dry;
      end
      default: begin
        op_a = DIFF_W'(dry);
        op_b = DIFF_W'(lp1);
        base = lp1;
      end
    endcase
  end

  assign diff      = op_a - op_b;
  assign prod_next = $signed({1'b0, coef}) * diff;

  // arithmetic shift gives floor division
  assign prod_sh  = prod >>> COEFF_BITS;
  assign sh       = prod_sh[SH_W-1:0];
  assign pole_sum = SH_W'(base) + sh;
  assign pole_new = pole_sum[STATE_BITS-1:0];

  assign blend    = BLEND_W'(base) + BLEND_W'(sh);
  assign blend_sh = blend >>> UP;
  assign fits     = (&blend_sh[BLEND_W-1:SAMPLE_BITS-1]) | ~(|blend_sh[BLEND_W-1:SAMPLE_BITS-1]);

  always_comb begin
    if (fits) begin
      blend_sat = blend_sh[SAMPLE_BITS-1:0];
    end else if (blend_sh[BLEND_W-1]) begin
      blend_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      blend_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp1 <= '0;
      lp2 <= '0;
      trk <= '0;
    end else if (cmd.add_en) begin
      case (cmd.step)
        STEP_LP1: lp1 <= pole_new;
        STEP_LP2: lp2 <= pole_new;
        STEP_TRK: trk <= pole_new;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_out <= cmd.bypass ? sample : blend_sat;
    end
    if (cmd.load) begin
      sample <= sample_in;
    end
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
  end

endmodule

>>> rtl/sbb_datapath.sv
// datapath: configuration registers, coefficient selection and the two channel lanes
// depends on sbb_pkg and sbb_lane
module sbb_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sbb_pkg::MIX_W-1:0]              cfg_data,
  input  sbb_pkg::cmd_t                          cmd,
  output sbb_pkg::status_t                       status,
  input  logic signed [sbb_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic signed [sbb_pkg::SAMPLE_BITS-1:0] right_in,
  output logic signed [sbb_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [sbb_pkg::SAMPLE_BITS-1:0] right_out
);
  import sbb_pkg::*;

  logic [COEFF_BITS-1:0] low_corner_coeff;
  logic [COEFF_BITS-1:0] high_corner_coeff;
  logic [MIX_W-1:0]      wet_mix;
  logic [MIX_W-1:0]      mix_eff;
  logic [MIX_W-1:0]      coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_corner_coeff  <= LOW_CORNER_RESET;
      high_corner_coeff <= HIGH_CORNER_RESET;
      wet_mix           <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW_CORNER:  low_corner_coeff  <= cfg_data[COEFF_BITS-1:0];
        CFG_HIGH_CORNER: high_corner_coeff <= cfg_data[COEFF_BITS-1:0];
        CFG_WET_MIX:     wet_mix           <= cfg_data;
        default:         ;
      endcase
    end
  end

  // anything at or above one is fully wet
  assign mix_eff = wet_mix[COEFF_BITS] ? MIX_ONE : wet_mix;
  assign status.mix_zero = (wet_mix == '0);

  always_comb begin
    case (cmd.step)
      STEP_LP1: coef = {1'b0, high_corner_coeff};
      STEP_LP2: coef = {1'b0, high_corner_coeff};
      STEP_TRK: coef = {1'b0, low_corner_coeff};
      STEP_MIX: coef = mix_eff;
      default:  coef = {1'b0, high_corner_coeff};
    endcase
  end

  sbb_lane u_left (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample_in  (left_in),
    .coef       (coef),
    .sample_out (left_out)
  );

  sbb_lane u_right (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample_in  (right_in),
    .coef       (coef),
    .sample_out (right_out)
  );

endmodule

>>> rtl/sbb_ctrl.sv
// controller: sequences the four multiply/add steps per sample and owns the handshakes
// depends on sbb_pkg
module sbb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sbb_pkg::status_t status,
  output sbb_pkg::cmd_t    cmd
);
  import sbb_pkg::*;

  state_t state, state_next;
  step_t  step, step_next;
  logic   out_free;
  logic   done;
  logic   out_valid_next;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_LP1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd.step     = step;
    cmd.load     = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.add_en   = 1'b0;
    cmd.out_load = 1'b0;
    cmd.bypass   = 1'b0;
    done         = 1'b0;
    in_ready     = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        case (step)
          STEP_LP1: begin
            cmd.add_en = 1'b1;
            step_next  = STEP_LP2;
            state_next = ST_MUL;
          end
          STEP_LP2: begin
            cmd.add_en = 1'b1;
            step_next  = STEP_TRK;
            state_next = ST_MUL;
          end
          STEP_TRK: begin
            cmd.add_en = 1'b1;
            step_next  = STEP_MIX;
            state_next = ST_MUL;
          end
          STEP_MIX: begin
            // hold the product until the output register can take the result
            if (out_free) begin
              cmd.out_load = 1'b1;
              done         = 1'b1;
              in_ready     = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_PASS: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.bypass   = 1'b1;
          done         = 1'b1;
          in_ready     = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (in_ready && in_valid) begin
      cmd.load   = 1'b1;
      step_next  = STEP_LP1;
      state_next = status.mix_zero ? ST_PASS : ST_MUL;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_mul_then_add: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |=> state == ST_ADD)
    else $error("multiply step not followed by add step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_MUL || state == ST_PASS)
    else $error("accepted transaction did not start processing");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("output register overwritten while a result waits");

  a_step_advance: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD && step != STEP_MIX |=> state == ST_MUL && step != $past(step))
    else $error("pole step did not advance");

  a_done_sets_valid: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid)
    else $error("finished result not presented");

endmodule

>>> rtl/stereo_cabinet_bandpass_blend_top.sv
// top level of the stereo cabinet band-pass blend
// depends on sbb_pkg, sbb_ctrl and sbb_datapath
//
// Input channel: in_valid/in_ready with left_in and right_in (signed Q1.23). A transaction
// is taken when both are high. Output channel: out_valid/out_ready with left_out and
// right_out, saturated Q1.23, one result per input transaction.
// Config port: cfg_we, cfg_index, cfg_data; index 0 low corner coefficient, 1 high corner
// coefficient, 2 wet mix. Writes take effect on the same edge; write only while idle.
// With mix nonzero an accepted sample runs four pole/blend steps, each one multiply state
// and one add state on a shared multiplier per channel, before out_valid; with mix zero
// the sample passes through the bypass state and filter state is untouched.
// With mix nonzero the next transaction waits for the four steps on each channel's one
// multiplier, and with mix zero one is taken per cycle while the receiver keeps up; a new
// transaction is taken in the cycle the previous result moves into the output register.
// Reset clears filter state and loads default coefficients with mix zero.
// When the receiver stalls, the result holds in the output register and the last step
// waits until the register frees.
module stereo_cabinet_bandpass_blend_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sbb_pkg::MIX_W-1:0]              cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [sbb_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic signed [sbb_pkg::SAMPLE_BITS-1:0] right_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [sbb_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [sbb_pkg::SAMPLE_BITS-1:0] right_out
);
  import sbb_pkg::*;

  cmd_t    cmd;
  status_t status;

  sbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sbb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .left_in   (left_in),
    .right_in  (right_in),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule
